// ===== sv/vte_pkg.sv =====
// ---------------------------------------------------------------------------
// vte_pkg
// Shared codes and types for the vertex transform engine.
// ---------------------------------------------------------------------------
package vte_pkg;

  localparam logic [1:0] MODE_AFFINE     = 2'd0;
  localparam logic [1:0] MODE_TRANSPOSED = 2'd1;
  localparam logic [1:0] MODE_PROJECTIVE = 2'd2;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_XFORM = 1'b1;

  // per-lane status carried down the divider pipe
  typedef struct packed {
    logic ovf;     // quotient too large for the divider width
    logic neg;     // quotient sign (numerator sign xor w sign)
    logic s_zero;  // numerator exactly zero
    logic s_neg;   // numerator negative
  } vte_lane_flags_t;

endpackage

// ===== sv/vertex_transform_engine.sv =====
// ---------------------------------------------------------------------------
// vertex_transform_engine
// 4x4 homogeneous vertex transform, signed fixed point, three modes.
// ---------------------------------------------------------------------------
// Pipeline: input register, products, sums, divider setup, divider steps
//   and output register; the divider step chain sets the depth.
// Throughput: one word per cycle while out_tready is high; each stage moves on its own, so
//   bubbles close up and input keeps flowing into empty stages while a result waits at the output.
// Load words write the matrix at acceptance and give no result.
// Reset (rst_n low, synchronous) clears stage valids and sets mode 0;
//   the matrix is not cleared.
module vertex_transform_engine #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  localparam int IN_DW  = ((4 + 4*COORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_DW = ((3*COORD_WIDTH + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_wdata,    // transform_mode
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,     // entry_index, entry_value, vec_x, vec_y, vec_z
  input  logic              in_tuser,     // func
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,    // out_x, out_y, out_z
  output logic              out_tuser     // zero_w
);
  import vte_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int SW = 2*CW + F + 1;   // exact sum width
  localparam int NW = SW + F;         // scaled numerator width
  localparam int QB = CW + 1;         // quotient bits kept
  localparam int NS = 5 + QB;         // stage count, last one is the output register

  // ---- input unpack
  logic [3:0]           in_idx;
  logic [CW-1:0]        in_val;
  logic signed [CW-1:0] in_x, in_y, in_z;

  assign in_idx = in_tdata[3:0];
  assign in_val = in_tdata[4 +: CW];
  assign in_x   = in_tdata[4+CW +: CW];
  assign in_y   = in_tdata[4+2*CW +: CW];
  assign in_z   = in_tdata[4+3*CW +: CW];

  // ---- config
  logic [1:0] mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_AFFINE;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  // ---- stage flow control: a stage loads when empty or when its word moves on
  logic [NS:1]   valid_r;
  logic [NS+1:1] ld;

  always_comb begin
    ld[NS+1] = out_tready;
    for (int i = NS; i >= 1; i--) begin
      ld[i] = !valid_r[i] || ld[i+1];
    end
  end

  assign in_tready = ld[1];

  logic in_acc, load_we, xform_acc;
  assign in_acc    = in_tvalid && in_tready;
  assign load_we   = in_acc && (in_tuser == FUNC_LOAD);
  assign xform_acc = in_acc && (in_tuser == FUNC_XFORM);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (ld[1]) begin
        valid_r[1] <= xform_acc;
      end
      for (int i = 2; i <= NS; i++) begin
        if (ld[i]) begin
          valid_r[i] <= valid_r[i-1];
        end
      end
    end
  end

  // ---- matrix store; coefficients captured with the vertex so later loads
  //      never reach words already in flight
  logic signed [CW-1:0] coef [4][4];

  vte_matrix #(.CW(CW)) u_matrix (
    .clk   (clk),
    .we    (load_we),
    .idx   (in_idx),
    .wdata (in_val),
    .mode  (mode_r),
    .coef  (coef)
  );

  logic signed [CW-1:0] vx1_r, vy1_r, vz1_r;
  logic signed [CW-1:0] coef1_r [4][4];

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      vx1_r   <= in_x;
      vy1_r   <= in_y;
      vz1_r   <= in_z;
      coef1_r <= coef;
    end
  end

  // per-word side info: projective flag, zero-w flag, divisor
  logic          proj_r [1:NS-1];
  logic          zw_r   [4:NS-1];
  logic [SW-1:0] den_r  [4:NS-1];

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      proj_r[1] <= (mode_r == MODE_PROJECTIVE);
    end
    for (int i = 2; i <= NS-1; i++) begin
      if (ld[i]) begin
        proj_r[i] <= proj_r[i-1];
      end
    end
    for (int i = 5; i <= NS-1; i++) begin
      if (ld[i]) begin
        zw_r[i]  <= zw_r[i-1];
        den_r[i] <= den_r[i-1];
      end
    end
  end

  // ---- stages 2 and 3: four dot-product lanes (x, y, z, w)
  logic signed [SW-1:0] sum3 [4];

  for (genvar j = 0; j < 4; j++) begin : g_lane
    vte_dot_lane #(.CW(CW), .F(F), .SW(SW)) u_dot (
      .clk    (clk),
      .en_mul (ld[2]),
      .en_sum (ld[3]),
      .vx     (vx1_r),
      .vy     (vy1_r),
      .vz     (vz1_r),
      .ca     (coef1_r[j][0]),
      .cb     (coef1_r[j][1]),
      .cc     (coef1_r[j][2]),
      .ct     (coef1_r[j][3]),
      .sum_r  (sum3[j])
    );
  end

  // ---- stage 4: affine result, divider setup
  logic [SW-1:0] w_mag;
  assign w_mag = sum3[3][SW-1] ? SW'(-sum3[3]) : SW'(sum3[3]);

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      zw_r[4]  <= (sum3[3] == '0);
      den_r[4] <= w_mag;
    end
  end

  logic [SW-1:0]       r_ch   [3][QB+1];
  logic [QB-1:0]       nlo_ch [3][QB+1];
  logic [QB-1:0]       q_ch   [3][QB+1];
  vte_lane_flags_t     fl_ch  [3][QB+1];
  logic [CW-1:0]       aff_ch [3][QB+1];

  for (genvar j = 0; j < 3; j++) begin : g_prep
    logic signed [SW-1:0] s, sh;
    logic [SW-1:0]        s_mag;
    logic [NW-1:0]        num, hi;
    logic                 fits;
    logic [CW-1:0]        aff;
    vte_lane_flags_t      fl;

    assign s     = sum3[j];
    assign sh    = s >>> F;   // floor
    assign fits  = (sh[SW-1:CW-1] == '0) || (sh[SW-1:CW-1] == '1);
    assign aff   = fits ? sh[CW-1:0] :
                   (s[SW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}});
    assign s_mag = s[SW-1] ? SW'(-s) : SW'(s);
    assign num   = {s_mag, {F{1'b0}}};
    assign hi    = num >> QB;

    assign fl.ovf    = hi >= NW'(w_mag);
    assign fl.neg    = s[SW-1] ^ sum3[3][SW-1];
    assign fl.s_zero = (s == '0);
    assign fl.s_neg  = s[SW-1];

    logic [SW-1:0]   r4_r;
    logic [QB-1:0]   nlo4_r;
    vte_lane_flags_t fl4_r;
    logic [CW-1:0]   aff4_r;

    always_ff @(posedge clk) begin
      if (ld[4]) begin
        r4_r   <= hi[SW-1:0];   // below the divisor unless ovf
        nlo4_r <= num[QB-1:0];
        fl4_r  <= fl;
        aff4_r <= aff;
      end
    end

    assign r_ch[j][0]   = r4_r;
    assign nlo_ch[j][0] = nlo4_r;
    assign q_ch[j][0]   = '0;
    assign fl_ch[j][0]  = fl4_r;
    assign aff_ch[j][0] = aff4_r;

    // ---- stages 5 .. NS-1: one quotient bit per stage
    for (genvar i = 0; i < QB; i++) begin : g_div
      vte_div_step #(.SW(SW), .QB(QB), .CW(CW)) u_step (
        .clk    (clk),
        .en     (ld[5+i]),
        .den    (den_r[4+i]),
        .r_in   (r_ch[j][i]),
        .nlo_in (nlo_ch[j][i]),
        .q_in   (q_ch[j][i]),
        .fl_in  (fl_ch[j][i]),
        .aff_in (aff_ch[j][i]),
        .r_r    (r_ch[j][i+1]),
        .nlo_r  (nlo_ch[j][i+1]),
        .q_r    (q_ch[j][i+1]),
        .fl_r   (fl_ch[j][i+1]),
        .aff_r  (aff_ch[j][i+1])
      );
    end
  end

  // ---- output stage: sign, saturation, zero-w override
  logic [CW-1:0] res    [3];
  logic [CW-1:0] out_r  [3];
  logic          out_zw_r;

  localparam logic [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic [QB-1:0] LIM_POS = {2'b00, {(CW-1){1'b1}}};
  localparam logic [QB-1:0] LIM_NEG = {2'b01, {(CW-1){1'b0}}};

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      logic [QB-1:0]   q;
      vte_lane_flags_t fl;
      logic            big;
      q   = q_ch[j][QB];
      fl  = fl_ch[j][QB];
      big = fl.ovf || (fl.neg ? (q > LIM_NEG) : (q > LIM_POS));
      if (!proj_r[NS-1]) begin
        res[j] = aff_ch[j][QB];
      end else if (zw_r[NS-1]) begin
        res[j] = fl.s_zero ? '0 : (fl.s_neg ? SAT_MIN : SAT_MAX);
      end else if (big) begin
        res[j] = fl.neg ? SAT_MIN : SAT_MAX;
      end else begin
        res[j] = fl.neg ? CW'(-q) : q[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[NS]) begin
      out_r    <= res;
      out_zw_r <= proj_r[NS-1] && zw_r[NS-1];
    end
  end

  assign out_tvalid = valid_r[NS];
  assign out_tuser  = out_zw_r;
  assign out_tdata  = OUT_DW'({out_r[2], out_r[1], out_r[0]});

endmodule

// ===== sv/vte_matrix.sv =====
// ---------------------------------------------------------------------------
// vte_matrix
// 16-entry matrix store with per-mode coefficient selection.
// ---------------------------------------------------------------------------
module vte_matrix #(
  parameter int CW = 32
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [3:0]           idx,
  input  logic [CW-1:0]        wdata,
  input  logic [1:0]           mode,
  output logic signed [CW-1:0] coef [4][4]
);
  import vte_pkg::*;

  logic [CW-1:0] mem_r [16];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[idx] <= wdata;
    end
  end

  // lane j: terms a, b, c (x, y, z multipliers) and translation t
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      for (int k = 0; k < 3; k++) begin
        if (mode == MODE_TRANSPOSED && j < 3) begin
          coef[j][k] = mem_r[j*4+k];
        end else begin
          coef[j][k] = mem_r[k*4+j];
        end
      end
      coef[j][3] = mem_r[12+j];
    end
  end

endmodule

// ===== sv/vte_dot_lane.sv =====
// ---------------------------------------------------------------------------
// vte_dot_lane
// Two-stage dot product: three products, then exact sum plus lifted offset.
// ---------------------------------------------------------------------------
module vte_dot_lane #(
  parameter int CW = 32,
  parameter int F  = 16,
  parameter int SW = 2*CW+F+1
) (
  input  logic                 clk,
  input  logic                 en_mul,
  input  logic                 en_sum,
  input  logic signed [CW-1:0] vx,
  input  logic signed [CW-1:0] vy,
  input  logic signed [CW-1:0] vz,
  input  logic signed [CW-1:0] ca,
  input  logic signed [CW-1:0] cb,
  input  logic signed [CW-1:0] cc,
  input  logic signed [CW-1:0] ct,
  output logic signed [SW-1:0] sum_r
);

  logic signed [2*CW-1:0] p0_r, p1_r, p2_r;
  logic signed [CW-1:0]   t_r;

  always_ff @(posedge clk) begin
    if (en_mul) begin
      p0_r <= vx * ca;
      p1_r <= vy * cb;
      p2_r <= vz * cc;
      t_r  <= ct;
    end
  end

  always_ff @(posedge clk) begin
    if (en_sum) begin
      sum_r <= SW'(p0_r) + SW'(p1_r) + SW'(p2_r) + (SW'(t_r) <<< F);
    end
  end

endmodule

// ===== sv/vte_div_step.sv =====
// ---------------------------------------------------------------------------
// vte_div_step
// One restoring division step, one quotient bit, registered.
// ---------------------------------------------------------------------------
module vte_div_step #(
  parameter int SW = 65,
  parameter int QB = 33,
  parameter int CW = 32
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [SW-1:0]             den,
  input  logic [SW-1:0]             r_in,
  input  logic [QB-1:0]             nlo_in,
  input  logic [QB-1:0]             q_in,
  input  vte_pkg::vte_lane_flags_t  fl_in,
  input  logic [CW-1:0]             aff_in,
  output logic [SW-1:0]             r_r,
  output logic [QB-1:0]             nlo_r,
  output logic [QB-1:0]             q_r,
  output vte_pkg::vte_lane_flags_t  fl_r,
  output logic [CW-1:0]             aff_r
);
  import vte_pkg::*;

  logic [SW:0] trial, diff;
  logic        ge;

  assign trial = {r_in, nlo_in[QB-1]};
  assign ge    = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (en) begin
      r_r   <= ge ? diff[SW-1:0] : trial[SW-1:0];
      q_r   <= {q_in[QB-2:0], ge};
      nlo_r <= {nlo_in[QB-2:0], 1'b0};
      fl_r  <= fl_in;
      aff_r <= aff_in;
    end
  end

endmodule

// ===== test/vertex_transform_engine_tb.sv =====
// ---------------------------------------------------------------------------
// vertex_transform_engine_tb
// Self-checking bench: loads matrices, streams vertices in all three modes,
// predicts each result with an exact-width fixed-point transform and
// compares field by field under random valid/ready gaps.
// ---------------------------------------------------------------------------
module vertex_transform_engine_tb;
  import vte_pkg::*;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam int IN_DW = 136;
  localparam int OUT_DW = 96;
  localparam int LATENCY = CW + 6;
  localparam int CYCLE_LIMIT = 1500000;
  localparam logic [1:0] MODE_SPARE = 2'd3;  // unused code, behaves as affine

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
    logic zw;
  } vertex_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_wdata = MODE_AFFINE;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DW-1:0] in_tdata = '0;  // entry_index, entry_value, vec_x, vec_y, vec_z
  logic in_tuser = FUNC_LOAD;       // func
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;     // out_x, out_y, out_z
  logic out_tuser;                  // zero_w

  // predictor state
  logic signed [CW-1:0] mat [16];
  logic [1:0] mode_q = MODE_AFFINE;
  vertex_result_t expected_vertices[$];
  int errors = 0;
  int cycles = 0;

  vertex_transform_engine #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report(input string what, input logic [CW-1:0] got, input logic [CW-1:0] exp);
    errors++;
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, exp, cycles);
  endtask

  function automatic logic [CW-1:0] saturate(input logic signed [127:0] v);
    logic signed [127:0] hi, lo;
    hi = (128'sd1 <<< (CW - 1)) - 1;
    lo = -(128'sd1 <<< (CW - 1));
    if (v > hi) return hi[CW-1:0];
    if (v < lo) return lo[CW-1:0];
    return v[CW-1:0];
  endfunction

  // exact sum x*a + y*b + z*c + t*2^FB
  function automatic logic signed [127:0] dot_lift(input logic signed [CW-1:0] x,
      input logic signed [CW-1:0] y, input logic signed [CW-1:0] z,
      input logic signed [CW-1:0] a, input logic signed [CW-1:0] b,
      input logic signed [CW-1:0] c, input logic signed [CW-1:0] t);
    logic signed [127:0] s;
    s = 128'(x) * 128'(a) + 128'(y) * 128'(b) + 128'(z) * 128'(c);
    return s + (128'(t) <<< FB);
  endfunction

  function automatic vertex_result_t transform_vertex(input logic signed [CW-1:0] x,
      input logic signed [CW-1:0] y, input logic signed [CW-1:0] z);
    vertex_result_t r;
    logic signed [127:0] s [3];
    logic signed [127:0] w, q, n;
    logic [CW-1:0] o [3];
    r.zw = 1'b0;
    for (int j = 0; j < 3; j++) begin
      if (mode_q == MODE_TRANSPOSED)
        s[j] = dot_lift(x, y, z, mat[j*4], mat[j*4+1], mat[j*4+2], mat[12+j]);
      else
        s[j] = dot_lift(x, y, z, mat[j], mat[4+j], mat[8+j], mat[12+j]);
    end
    if (mode_q == MODE_PROJECTIVE) begin
      w = dot_lift(x, y, z, mat[3], mat[7], mat[11], mat[15]);
      for (int j = 0; j < 3; j++) begin
        if (w == 0) begin
          r.zw = 1'b1;
          if (s[j] == 0) o[j] = '0;
          else o[j] = (s[j] < 0) ? saturate(-(128'sd1 <<< 100)) : saturate(128'sd1 <<< 100);
        end else begin
          // numerator below 2^112 after lift, so a signed 128-bit divide is exact
          n = s[j] <<< FB;
          q = n / w;  // truncates toward zero
          o[j] = saturate(q);
        end
      end
    end else begin
      for (int j = 0; j < 3; j++) o[j] = saturate(s[j] >>> FB);
    end
    r.x = o[0];
    r.y = o[1];
    r.z = o[2];
    return r;
  endfunction

  // result checker with random stalls
  initial begin
    int stall;
    vertex_result_t exp, got;
    forever begin
      @(negedge clk);
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if ($urandom_range(0, 2) == 0) stall = 0;
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got = {out_tdata[CW-1:0], out_tdata[2*CW-1:CW], out_tdata[3*CW-1:2*CW], out_tuser};
      if (expected_vertices.size() == 0) begin
        report("unexpected result", got.x, '0);
      end else begin
        exp = expected_vertices.pop_front();
        if (got.x !== exp.x) report("out_x", got.x, exp.x);
        if (got.y !== exp.y) report("out_y", got.y, exp.y);
        if (got.z !== exp.z) report("out_z", got.z, exp.z);
        if (got.zw !== exp.zw)
          report("zero_w", {{(CW-1){1'b0}}, got.zw}, {{(CW-1){1'b0}}, exp.zw});
      end
    end
  end

  bit gaps_on = 1'b1;

  // one word to the block; predictor updates at acceptance
  task automatic send_word(input logic func, input logic [3:0] idx,
      input logic [CW-1:0] val, input logic [CW-1:0] x,
      input logic [CW-1:0] y, input logic [CW-1:0] z);
    int gap;
    gap = gaps_on ? $urandom_range(0, 13) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= func;
    in_tdata <= {4'b0, z, y, x, val, idx};
    do @(posedge clk); while (!in_tready);
    if (func == FUNC_LOAD) mat[idx] = val;
    else expected_vertices.push_back(transform_vertex(x, y, z));
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_vertices.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic set_mode(input logic [1:0] m);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we <= 1'b0;
    mode_q = m;
  endtask

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom;
      default: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
    endcase
  endfunction

  function automatic logic [CW-1:0] rand_small();
    return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
  endfunction

  task automatic load_matrix(input bit full_range);
    for (int i = 0; i < 16; i++)
      send_word(FUNC_LOAD, i[3:0], full_range ? rand_coord() : rand_small(), $urandom,
                $urandom, $urandom);
  endtask

  task automatic send_vertex();
    send_word(FUNC_XFORM, 4'($urandom), $urandom, rand_coord(), rand_coord(), rand_coord());
  endtask

  // identity matrix, extreme coordinate values, every mode
  task automatic test_directed();
    for (int i = 0; i < 16; i++)
      send_word(FUNC_LOAD, i[3:0], (i % 5 == 0) ? 32'h0001_0000 : 32'h0, 0, 0, 0);
    send_word(FUNC_XFORM, 4'hf, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h0);
    send_word(FUNC_XFORM, 4'h0, 32'h0, 32'hffff_ffff, 32'h0001_0000, 32'h8000_0001);
    send_word(FUNC_LOAD, 4'd12, 32'h7fff_ffff, 0, 0, 0);   // translation pushes x over
    send_word(FUNC_XFORM, 4'h0, 32'h0, 32'h7fff_ffff, 32'h0, 32'h0);
    set_mode(MODE_TRANSPOSED);
    send_word(FUNC_LOAD, 4'd1, 32'h8000_0000, 0, 0, 0);
    send_word(FUNC_XFORM, 4'h0, 32'h0, 32'h0002_0000, 32'h7fff_ffff, 32'hffff_0000);
    set_mode(MODE_PROJECTIVE);
    send_word(FUNC_XFORM, 4'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0);
    send_word(FUNC_LOAD, 4'd15, 32'h0, 0, 0, 0);           // w becomes zero
    send_word(FUNC_XFORM, 4'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_word(FUNC_XFORM, 4'h0, 32'h0, 32'h0001_0000, 32'hffff_0000, 32'h0);
    send_word(FUNC_LOAD, 4'd15, 32'hffff_fff0, 0, 0, 0);   // tiny negative w
    send_word(FUNC_XFORM, 4'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0);
    set_mode(MODE_SPARE);
    send_word(FUNC_XFORM, 4'h0, 32'h0, 32'h0003_0000, 32'h0, 32'h0);
  endtask

  // random matrices and vertices across the modes
  task automatic test_random(input logic [1:0] m, input int n);
    set_mode(m);
    load_matrix(1'($urandom_range(0, 1)));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 39) == 0) begin
        // zero one w-column entry; the zero-w path in projective mode is hit once all four are zero
        send_word(FUNC_LOAD, 4'd3 + 4'($urandom_range(0, 3) * 4), 32'h0, 0, 0, 0);
      end else if ($urandom_range(0, 19) == 0) begin
        send_word(FUNC_LOAD, 4'($urandom), rand_coord(), $urandom, $urandom, $urandom);
      end else begin
        send_vertex();
      end
      if (i == n / 2) gaps_on = ~gaps_on;
    end
    gaps_on = 1'b1;
  endtask

  // sender holds until every result is back, then a back-to-back burst
  task automatic test_burst();
    wait_idle();
    gaps_on = 1'b0;
    for (int i = 0; i < 60; i++) send_vertex();
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random(MODE_AFFINE, 450);
    test_random(MODE_TRANSPOSED, 450);
    test_random(MODE_PROJECTIVE, 450);
    test_burst();
    test_random(MODE_SPARE, 150);
    test_random(MODE_PROJECTIVE, 200);
    wait_idle();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
